// File: rtl/cma_pkg.sv
`timescale 1ns / 1ps
// cma_pkg: shared constants for the centered moving average block.
// No dependencies; imported by the configuration interface, the top level and the testbench.
package cma_pkg;

    localparam int CFG_BITS = 6;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 6'd3;

    localparam int SEEN_BITS = 7;
    localparam logic [SEEN_BITS-1:0] SEEN_MAX = '1;

    typedef logic [CFG_BITS-1:0] cfg_word_t;
    typedef logic [SEEN_BITS-1:0] seen_t;

endpackage

// File: rtl/cma_ifs.sv
`timescale 1ns / 1ps
// cma_ifs: valid/ready channel interfaces for samples, averages and configuration.
// Depends on cma_pkg.
interface cma_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          last_in;

    modport source (output valid, output sample_in, output last_in, input ready);
    modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface cma_out_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] avg_out;
    logic                          last_out;

    modport source (output valid, output avg_out, output last_out, input ready);
    modport sink   (input valid, input avg_out, input last_out, output ready);
endinterface

interface cma_cfg_if import cma_pkg::*; ();
    logic      valid;
    logic      ready;
    cfg_word_t win_len;

    modport source (output valid, output win_len, input ready);
    modport sink   (input valid, input win_len, output ready);
endinterface

// File: rtl/cma_ram.sv
`timescale 1ns / 1ps
// cma_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module cma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 63,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/cma_div.sv
`timescale 1ns / 1ps
// cma_div: restoring divider, one quotient bit per cycle, truncates toward zero.
// Depends on cma_pkg only through the top level; standalone arithmetic.
module cma_div #(
    parameter int SUM_BITS    = 22,
    parameter int WIN_BITS    = 6,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SUM_BITS-1:0]    dividend,
    input  logic        [WIN_BITS-1:0]    divisor,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] quotient
);

    localparam int CW = $clog2(SUM_BITS + 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [SUM_BITS-1:0]           q_reg, q_next;
    logic [WIN_BITS-1:0]           r_reg, r_next;
    logic [WIN_BITS-1:0]           d_reg, d_next;
    logic                          neg_reg, neg_next;
    logic signed [SAMPLE_BITS-1:0] quo_reg, quo_next;

    logic [WIN_BITS:0]   trial;
    logic [WIN_BITS:0]   r_step;
    logic                fits;
    logic [SUM_BITS-1:0] q_step;
    logic [SUM_BITS-1:0] q_fix;

    always_comb
    begin
        trial  = {r_reg, q_reg[SUM_BITS-1]};
        fits   = (trial >= {1'b0, d_reg});
        r_step = fits ? (trial - {1'b0, d_reg}) : trial;
        q_step = {q_reg[SUM_BITS-2:0], fits};
        q_fix  = neg_reg ? (~q_step + 1'b1) : q_step;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(SUM_BITS);
            q_next    = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
            r_next    = '0;
            d_next    = divisor;
            neg_next  = dividend[SUM_BITS-1];
        end
        else if (busy_reg)
        begin
            q_next   = q_step;
            r_next   = r_step[WIN_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                quo_next  = q_fix[SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= '0;
            r_reg    <= '0;
            d_reg    <= '0;
            neg_reg  <= 1'b0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            q_reg    <= q_next;
            r_reg    <= r_next;
            d_reg    <= d_next;
            neg_reg  <= neg_next;
            quo_reg  <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/centered_moving_average_top.sv
`timescale 1ns / 1ps
// centered_moving_average_top: centered moving average over a sample stream.
// Depends on cma_pkg, cma_ifs, cma_ram and cma_div.
//
//   channel   dir  handshake    beat contents
//   samples   in   valid/ready  sample_in, last_in
//   averages  out  valid/ready  avg_out, last_out
//   cfg       in   valid/ready  win_len (always ready)
//
// One sample at a time. After a sample whose average is divided, ready stays low while the
// one-bit-per-cycle restoring divider works and until the sample's beats are emitted.
// The first sample after a win_len write re-sums its window of history from the RAM.
// Edge samples skip the divider; a flush gives one beat per cycle while averages is ready.
// A full output register holds the sample in its emit step until averages takes the beat.
// Reset clears history valid bits, running sum, count and window (to 3) at once.
module centered_moving_average_top import cma_pkg::*; #(
    parameter int MAX_WINDOW  = 63,
    parameter int SAMPLE_BITS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    cma_in_if.sink   samples,
    cma_out_if.source averages,
    cma_cfg_if.sink  cfg
);

    localparam int WIN_BITS = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS = SAMPLE_BITS + WIN_BITS;
    localparam int AW       = $clog2(MAX_WINDOW);
    localparam int CAP_RAW  = (MAX_WINDOW - 1) | 1;
    localparam int CAP      = (CAP_RAW > MAX_WINDOW) ? CAP_RAW - 2 : CAP_RAW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OLD,
        S_SUM_RD,
        S_SUM_ACC,
        S_DECIDE,
        S_DIV,
        S_EMIT,
        S_FIN
    } state_t;

    state_t                        state_reg, state_next;
    cfg_word_t                     cfg_reg, cfg_next;
    logic signed [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic                          lst_reg, lst_next;
    seen_t                         k_reg, k_next;
    seen_t                         seen_reg, seen_next;
    logic [WIN_BITS-1:0]           w_reg, w_next;
    logic [WIN_BITS-1:0]           h_reg, h_next;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [WIN_BITS-1:0]           j_reg, j_next;
    logic [WIN_BITS-1:0]           rem_reg, rem_next;
    logic                          first_reg, first_next;
    logic                          resum_reg, resum_next;
    logic [AW-1:0]                 wp_reg, wp_next;
    logic [AW-1:0]                 nw_reg, nw_next;
    logic [MAX_WINDOW-1:0]         vld_reg, vld_next;
    logic                          rdv_reg, rdv_next;
    logic                          ov_reg, ov_next;
    logic signed [SAMPLE_BITS-1:0] avg_reg, avg_next;
    logic                          lout_reg, lout_next;

    logic [31:0]                w_wide;
    logic [WIN_BITS-1:0]        w_eff;
    logic [31:0]                oa;
    logic [31:0]                sa;
    logic [AW-1:0]              raddr;
    logic [SAMPLE_BITS-1:0]     ram_q;
    logic signed [SUM_BITS-1:0] rd_ext;
    logic signed [SUM_BITS-1:0] smp_ext;
    logic [31:0]                kw;
    logic [31:0]                hw;
    logic                       regular;
    logic                       divide;
    logic [31:0]                total;
    logic                       div_start;
    logic                       div_done;
    logic signed [SAMPLE_BITS-1:0] div_q;

    // effective window and RAM addressing
    always_comb
    begin
        w_wide = 32'(cfg_reg) | 32'd1;
        if (w_wide > 32'(CAP))
        begin
            w_wide = 32'(CAP);
        end
        w_eff = w_wide[WIN_BITS-1:0];

        oa = 32'(wp_reg) + 32'(MAX_WINDOW) - 32'(w_eff);
        if (oa >= 32'(MAX_WINDOW))
        begin
            oa = oa - 32'(MAX_WINDOW);
        end

        sa = 32'(nw_reg) + 32'(MAX_WINDOW) - 32'(j_reg);
        if (sa >= 32'(MAX_WINDOW))
        begin
            sa = sa - 32'(MAX_WINDOW);
        end

        raddr = (state_reg == S_IDLE) ? oa[AW-1:0] : sa[AW-1:0];
    end

    assign rd_ext  = rdv_reg ? SUM_BITS'($signed(ram_q)) : '0;
    assign smp_ext = SUM_BITS'(smp_reg);

    // output plan for the current sample
    always_comb
    begin
        kw      = 32'(k_reg);
        hw      = 32'(h_reg);
        regular = (kw >= hw);
        divide  = (kw >= (hw << 1));
        total   = 32'(regular);
        if (lst_reg)
        begin
            total = total + (regular ? hw : (kw + 32'd1));
        end
    end

    assign div_start = (state_reg == S_DECIDE) && regular && divide;

    always_comb
    begin
        state_next = state_reg;
        cfg_next   = cfg_reg;
        smp_next   = smp_reg;
        lst_next   = lst_reg;
        k_next     = k_reg;
        seen_next  = seen_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        sum_next   = sum_reg;
        j_next     = j_reg;
        rem_next   = rem_reg;
        first_next = first_reg;
        resum_next = resum_reg;
        wp_next    = wp_reg;
        nw_next    = nw_reg;
        vld_next   = vld_reg;
        rdv_next   = vld_reg[raddr];
        ov_next    = ov_reg;
        avg_next   = avg_reg;
        lout_next  = lout_reg;

        if (ov_reg && averages.ready)
        begin
            ov_next = 1'b0;
        end

        if (cfg.valid)
        begin
            cfg_next   = cfg.win_len;
            resum_next = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                begin
                    smp_next   = samples.sample_in;
                    lst_next   = samples.last_in;
                    k_next     = seen_reg;
                    w_next     = w_eff;
                    h_next     = w_eff >> 1;
                    state_next = S_OLD;
                end
            end
            S_OLD:
            begin
                vld_next[wp_reg] = 1'b1;
                nw_next          = wp_reg;
                wp_next          = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : (wp_reg + 1'b1);
                if (resum_reg)
                begin
                    sum_next   = smp_ext;
                    j_next     = WIN_BITS'(1);
                    resum_next = 1'b0;
                    state_next = (w_reg > WIN_BITS'(1)) ? S_SUM_RD : S_DECIDE;
                end
                else
                begin
                    sum_next   = sum_reg - rd_ext + smp_ext;
                    state_next = S_DECIDE;
                end
            end
            S_SUM_RD:
            begin
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                sum_next = sum_reg + rd_ext;
                j_next   = j_reg + 1'b1;
                state_next = (j_reg == (w_reg - 1'b1)) ? S_DECIDE : S_SUM_RD;
            end
            S_DECIDE:
            begin
                rem_next   = total[WIN_BITS-1:0];
                first_next = regular && divide;
                if (div_start)
                begin
                    state_next = S_DIV;
                end
                else if (total != 32'd0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || averages.ready)
                begin
                    ov_next    = 1'b1;
                    avg_next   = first_reg ? div_q : '0;
                    lout_next  = lst_reg && (rem_reg == WIN_BITS'(1));
                    first_next = 1'b0;
                    rem_next   = rem_reg - 1'b1;
                    if (rem_reg == WIN_BITS'(1))
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (lst_reg)
                begin
                    vld_next  = '0;
                    sum_next  = '0;
                    seen_next = '0;
                end
                else
                begin
                    seen_next = (k_reg < SEEN_MAX) ? (k_reg + 1'b1) : k_reg;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cfg_reg   <= CFG_RESET;
            smp_reg   <= '0;
            lst_reg   <= 1'b0;
            k_reg     <= '0;
            seen_reg  <= '0;
            w_reg     <= '0;
            h_reg     <= '0;
            sum_reg   <= '0;
            j_reg     <= '0;
            rem_reg   <= '0;
            first_reg <= 1'b0;
            resum_reg <= 1'b0;
            wp_reg    <= '0;
            nw_reg    <= '0;
            vld_reg   <= '0;
            rdv_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            avg_reg   <= '0;
            lout_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cfg_reg   <= cfg_next;
            smp_reg   <= smp_next;
            lst_reg   <= lst_next;
            k_reg     <= k_next;
            seen_reg  <= seen_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            sum_reg   <= sum_next;
            j_reg     <= j_next;
            rem_reg   <= rem_next;
            first_reg <= first_next;
            resum_reg <= resum_next;
            wp_reg    <= wp_next;
            nw_reg    <= nw_next;
            vld_reg   <= vld_next;
            rdv_reg   <= rdv_next;
            ov_reg    <= ov_next;
            avg_reg   <= avg_next;
            lout_reg  <= lout_next;
        end
    end

    cma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .clk   (clk),
        .we    (state_reg == S_OLD),
        .waddr (wp_reg),
        .wdata (smp_reg),
        .raddr (raddr),
        .rdata (ram_q)
    );

    cma_div #(
        .SUM_BITS    (SUM_BITS),
        .WIN_BITS    (WIN_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (w_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign samples.ready     = (state_reg == S_IDLE);
    assign averages.valid    = ov_reg;
    assign averages.avg_out  = avg_reg;
    assign averages.last_out = lout_reg;
    assign cfg.ready         = 1'b1;

endmodule

// File: rtl/cma_checker.sv
`timescale 1ns / 1ps
// cma_checker: port-level assertions for centered_moving_average_top, plus its bind.
// Depends on centered_moving_average_top and cma_ifs.
module cma_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] avg_out,
    input logic                          last_out,
    input logic                          cfg_ready
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(avg_out) && $stable(last_out))
        else $error("output beat changed while stalled");

    // after an accepted sample, input ready stays low while the unit works on it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input ready too soon after a beat");

    // new output beats come only from the emit sequence, never from idle
    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("output beat appeared while idle");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind centered_moving_average_top cma_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_cma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (averages.valid),
    .out_ready (averages.ready),
    .avg_out   (averages.avg_out),
    .last_out  (averages.last_out),
    .cfg_ready (cfg.ready)
);

// File: verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for centered_moving_average_top: directed table, random, long signals.
// Depends on cma_pkg, cma_ifs and the RTL top; predicts every average beat in-bench.
module tb import cma_pkg::*; ();

    localparam int MAXW       = 63;
    localparam int SBITS      = 16;
    localparam int SETTLE     = 200;
    localparam int HOLD       = 600;
    localparam int LIMIT_NS   = 2_000_000;
    localparam int NDIR       = 24;
    localparam int RAND_ITEMS = 24;
    localparam int LONG_LEN   = 66;

    typedef struct packed {
        logic signed [SBITS-1:0] avg;
        logic                    last;
    } avg_beat_t;

    typedef struct packed {
        logic                    wr;
        cfg_word_t               win;
        logic signed [SBITS-1:0] smp;
        logic                    lst;
        int                      n_typed;
        logic signed [SBITS-1:0] avg0;
    } dir_row_t;

    logic clk;
    logic rst_n;

    cma_in_if  #(.SAMPLE_BITS(SBITS)) samples ();
    cma_out_if #(.SAMPLE_BITS(SBITS)) averages ();
    cma_cfg_if cfg ();

    centered_moving_average_top #(
        .MAX_WINDOW  (MAXW),
        .SAMPLE_BITS (SBITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .averages (averages),
        .cfg      (cfg)
    );

    logic signed [SBITS-1:0] history [MAXW];
    seen_t                   seen_cnt;
    cfg_word_t               win_reg;
    avg_beat_t               avg_q [$];
    avg_beat_t               fresh_q [$];
    avg_beat_t               got_b;
    dir_row_t                dir_tab [NDIR];

    int  errors;
    int  n_samples;
    int  n_signals;
    int  n_checked;
    int  n_cfg;
    int  burst_left;
    bit  steady;
    bit  hold_req;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #(LIMIT_NS);
        $display("centered_moving_average_top: mismatch");
        $finish;
    end

    // averages of the w samples centered on each output, zeros at the signal edges
    task automatic smooth_sample(input logic signed [SBITS-1:0] smp, input logic lst);
        int w;
        int h;
        int k;
        int sum;
        int flush;
        logic signed [SBITS-1:0] avg;
        w = int'(win_reg | 6'd1);
        h = w >> 1;
        k = int'(seen_cnt);
        for (int i = MAXW - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0] = smp;
        sum = 0;
        for (int i = 0; i < w; i++)
            sum += history[i];
        if (k >= h)
        begin
            avg = (k >= 2 * h) ? SBITS'(sum / w) : '0;
            fresh_q.push_back('{avg, 1'b0});
        end
        if (lst)
        begin
            flush = (k >= h) ? h : k + 1;
            repeat (flush) fresh_q.push_back('{'0, 1'b0});
            fresh_q[fresh_q.size()-1].last = 1'b1;
            for (int i = 0; i < MAXW; i++)
                history[i] = '0;
            seen_cnt = '0;
        end
        else
        begin
            seen_cnt = (seen_cnt != SEEN_MAX) ? seen_cnt + 1'b1 : SEEN_MAX;
        end
    endtask

    task automatic send_sample(input logic signed [SBITS-1:0] smp, input logic lst,
                               input int n_typed, input logic signed [SBITS-1:0] avg0);
        int g;
        if (!steady && burst_left == 0)
        begin
            g = $urandom_range(1, 6);
            samples.valid <= 1'b0;
            repeat (g) @(negedge clk);
            burst_left = $urandom_range(1, 8);
        end
        if (burst_left > 0)
            burst_left--;
        samples.valid     <= 1'b1;
        samples.sample_in <= smp;
        samples.last_in   <= lst;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        fresh_q.delete();
        smooth_sample(smp, lst);
        if (n_typed < 0)
        begin
            foreach (fresh_q[i])
                avg_q.push_back(fresh_q[i]);
        end
        else
        begin
            for (int i = 0; i < n_typed; i++)
                avg_q.push_back('{(i == 0) ? avg0 : '0, lst && (i == n_typed - 1)});
        end
        n_samples++;
        if (lst)
            n_signals++;
        @(negedge clk);
    endtask

    task automatic settle();
        samples.valid <= 1'b0;
        wait (avg_q.size() == 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_window(input cfg_word_t v);
        settle();
        cfg.valid   <= 1'b1;
        cfg.win_len <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        win_reg = v;
        n_cfg++;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic cfg_word_t pick_window();
        case ($urandom_range(0, 5))
            0:       return cfg_word_t'($urandom_range(0, 1));
            1:       return cfg_word_t'($urandom_range(62, 63));
            2:       return cfg_word_t'($urandom);
            default: return cfg_word_t'($urandom_range(0, 12));
        endcase
    endfunction

    function automatic logic signed [SBITS-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return '1;
            default: return SBITS'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && averages.valid && averages.ready)
        begin
            if (avg_q.size() == 0)
            begin
                $error("unexpected beat: avg_out %0d last_out %0b",
                       averages.avg_out, averages.last_out);
                errors++;
            end
            else
            begin
                got_b = avg_q.pop_front();
                if (averages.avg_out !== got_b.avg)
                begin
                    $error("avg_out: expected %0d, actual %0d", got_b.avg, averages.avg_out);
                    errors++;
                end
                if (averages.last_out !== got_b.last)
                begin
                    $error("last_out: expected %0b, actual %0b", got_b.last, averages.last_out);
                    errors++;
                end
                n_checked++;
            end
        end
    end

    // receiver: random stall patterns, plus one long hold-off on request
    initial
    begin
        int mode;
        int left;
        averages.ready = 1'b0;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                averages.ready <= 1'b0;
                for (int n = 0; n < HOLD; n++)
                    @(negedge clk);
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
                0:       averages.ready <= 1'b1;
                1:       averages.ready <= 1'($urandom_range(0, 1));
                default: averages.ready <= ((left % 8) < 5);
            endcase
        end
    end

    initial
    begin
        int len;
        int rand_sent;
        logic signed [SBITS-1:0] smp;

        rst_n             = 1'b0;
        samples.valid     = 1'b0;
        samples.sample_in = '0;
        samples.last_in   = 1'b0;
        cfg.valid         = 1'b0;
        cfg.win_len       = '0;
        errors    = 0;
        n_samples = 0;
        n_signals = 0;
        n_checked = 0;
        n_cfg     = 0;
        burst_left = 0;
        steady    = 1'b0;
        hold_req  = 1'b0;
        win_reg   = CFG_RESET;
        seen_cnt  = '0;
        for (int i = 0; i < MAXW; i++)
            history[i] = '0;

        // wr, window, sample, last, typed beat count (-1: predicted), first average
        dir_tab = '{
            '{1'b0, 6'd0,  16'sd100,    1'b0, 0,  16'sd0},
            '{1'b0, 6'd0,  16'sd200,    1'b0, 1,  16'sd0},
            '{1'b0, 6'd0,  16'sd300,    1'b0, 1,  16'sd200},
            '{1'b0, 6'd0,  -16'sd7,     1'b1, 2,  16'sd164},
            '{1'b1, 6'd0,  16'sh7fff,   1'b0, 1,  16'sh7fff},
            '{1'b0, 6'd0,  16'sh8000,   1'b0, 1,  16'sh8000},
            '{1'b0, 6'd0,  -16'sd1,     1'b1, 1,  -16'sd1},
            '{1'b1, 6'd63, 16'sh8000,   1'b1, 1,  16'sd0},
            '{1'b0, 6'd0,  16'sh7fff,   1'b0, 0,  16'sd0},
            '{1'b0, 6'd0,  16'sh7fff,   1'b0, 0,  16'sd0},
            '{1'b0, 6'd0,  16'sh7fff,   1'b1, 3,  16'sd0},
            '{1'b1, 6'd4,  16'sh7fff,   1'b0, -1, 16'sd0},
            '{1'b0, 6'd0,  16'sh8000,   1'b0, -1, 16'sd0},
            '{1'b0, 6'd0,  16'sh7fff,   1'b0, -1, 16'sd0},
            '{1'b0, 6'd0,  16'sh8000,   1'b0, -1, 16'sd0},
            '{1'b0, 6'd0,  16'sh7fff,   1'b0, -1, 16'sd0},
            '{1'b0, 6'd0,  -16'sd1,     1'b0, -1, 16'sd0},
            '{1'b0, 6'd0,  16'sd0,      1'b1, -1, 16'sd0},
            '{1'b1, 6'd2,  -16'sd5,     1'b0, -1, 16'sd0},
            '{1'b0, 6'd0,  -16'sd3,     1'b0, -1, 16'sd0},
            '{1'b0, 6'd0,  -16'sd2,     1'b0, -1, 16'sd0},
            '{1'b1, 6'd6,  16'sd1,      1'b0, -1, 16'sd0},
            '{1'b0, 6'd0,  16'sd2,      1'b0, -1, 16'sd0},
            '{1'b0, 6'd0,  16'sd3,      1'b1, -1, 16'sd0}
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[r])
        begin
            if (dir_tab[r].wr)
                write_window(dir_tab[r].win);
            send_sample(dir_tab[r].smp, dir_tab[r].lst, dir_tab[r].n_typed, dir_tab[r].avg0);
        end
        settle();

        rand_sent = 0;
        while (rand_sent < RAND_ITEMS)
        begin
            if ($urandom_range(0, 1))
                write_window(pick_window());
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(1, 3);
                1:       len = $urandom_range(10, 16);
                default: len = $urandom_range(2, 8);
            endcase
            if (len > RAND_ITEMS - rand_sent)
                len = RAND_ITEMS - rand_sent;
            steady = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < len; j++)
            begin
                if (len > 8 && j == len / 2 && $urandom_range(0, 4) == 0)
                    write_window(pick_window());
                smp = pick_sample();
                send_sample(smp, j == len - 1, -1, '0);
                rand_sent++;
            end
        end

        // long signal at the widest window, with a long receiver hold-off at its start
        write_window(cfg_word_t'($urandom_range(62, 63)));
        steady   = 1'b1;
        hold_req = 1'b1;
        for (int j = 0; j < LONG_LEN; j++)
            send_sample(pick_sample(), j == LONG_LEN - 1, -1, '0);

        settle();
        $display("%0d samples in %0d signals, %0d window writes, %0d average beats checked",
                 n_samples, n_signals, n_cfg, n_checked);
        if (errors == 0)
            $display("centered_moving_average_top: match");
        else
            $display("centered_moving_average_top: mismatch");
        $finish;
    end

endmodule
